@@ rtl/snf_pkg.sv @@
// Shared types, constants and the digit-to-segment table for the seven-segment
// number formatter. No dependencies; every other file in rtl/ refers to it.
package snf_pkg;

    localparam logic [7:0] ADDR_BYTE = 8'hC0;
    localparam logic [7:0] CTRL_BASE = 8'h80;
    localparam logic [7:0] DASH_SEG  = 8'h40;
    localparam logic [7:0] POINT_SEG = 8'h80;
    localparam logic [7:0] BLANK_SEG = 8'h00;

    // Number of bytes held in the frame shift register: address plus 16 data bytes.
    localparam int unsigned FRAME_BYTES = 17;

    // Position of the control byte for each frame length.
    localparam logic [4:0] LAST_POS_NONE = 5'd1;
    localparam logic [4:0] LAST_POS_ONE  = 5'd9;
    localparam logic [4:0] LAST_POS_BOTH = 5'd17;

    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_DATA = 2'd1,
        KIND_CMD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] mag_first;
        logic        neg_first;
        logic [1:0]  point_first;
        logic [15:0] mag_second;
        logic        neg_second;
        logic [1:0]  point_second;
        logic [7:0]  bright_level;
        logic        display_on;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       last;
    } result_t;

    // What one lane hands to the merge stage: four segment bytes, thousands first,
    // and a flag that ends the frame before this number.
    typedef struct packed {
        logic [3:0][7:0] seg;
        logic            stop;
    } lane_res_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = BLANK_SEG;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/snf_lane.sv @@
// One formatting lane: splits a magnitude into decimal digits by reciprocal
// multiplication and turns them into four segment bytes. Depends on snf_pkg.
module snf_lane
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [15:0]          mag,
    input  logic                 neg,
    input  logic [1:0]           point,
    output snf_pkg::lane_res_t   res
);

    logic [27:0] prod_1000;
    logic [26:0] prod_100;
    logic [29:0] prod_10;

    logic [3:0]  q1000_reg;
    logic [6:0]  q100_reg;
    logic [9:0]  q10_reg;
    logic [13:0] mag_reg;
    logic        neg_reg;
    logic [1:0]  point_reg;
    logic        ovf_reg;
    logic        stop_reg;

    // Exact for every magnitude up to 9999; larger values are shown as dashes.
    assign prod_1000 = {14'd0, mag[13:0]} * 28'd8389;
    assign prod_100  = {13'd0, mag[13:0]} * 27'd5243;
    assign prod_10   = {16'd0, mag[13:0]} * 30'd52429;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q1000_reg <= prod_1000[26:23];
            q100_reg  <= prod_100[25:19];
            q10_reg   <= prod_10[28:19];
            mag_reg   <= mag[13:0];
            neg_reg   <= neg;
            point_reg <= point;
            ovf_reg   <= (mag > 16'd9999);
            stop_reg  <= neg && (mag >= 16'd2000);
        end
    end

    logic [6:0]  tens_of_th;
    logic [9:0]  tens_of_h;
    logic [13:0] tens_of_t;
    logic [3:0]  dig_h;
    logic [3:0]  dig_t;
    logic [3:0]  dig_u;
    logic [7:0]  sign_add;

    assign tens_of_th = {3'd0, q1000_reg} * 7'd10;
    assign tens_of_h  = {3'd0, q100_reg} * 10'd10;
    assign tens_of_t  = {4'd0, q10_reg} * 14'd10;
    assign dig_h      = 4'(q100_reg - tens_of_th);
    assign dig_t      = 4'(q10_reg - tens_of_h);
    assign dig_u      = 4'(mag_reg - tens_of_t);
    assign sign_add   = neg_reg ? snf_pkg::DASH_SEG : snf_pkg::BLANK_SEG;

    always_comb
    begin
        res.stop = stop_reg;
        if (ovf_reg)
        begin
            res.seg = {4{snf_pkg::DASH_SEG}};
        end
        else
        begin
            // The sum of segment, point and minus wraps at eight bits.
            if (point_reg >= 2'd2 || q1000_reg != 4'd0)
                res.seg[0] = snf_pkg::seg_of(q1000_reg)
                           + ((point_reg == 2'd3) ? snf_pkg::POINT_SEG : snf_pkg::BLANK_SEG)
                           + sign_add;
            else
                res.seg[0] = sign_add;

            if (point_reg >= 2'd1 || q100_reg != 7'd0)
                res.seg[1] = snf_pkg::seg_of(dig_h)
                           + ((point_reg == 2'd2) ? snf_pkg::POINT_SEG : snf_pkg::BLANK_SEG);
            else
                res.seg[1] = snf_pkg::BLANK_SEG;

            res.seg[2] = snf_pkg::seg_of(dig_t)
                       + ((point_reg == 2'd1) ? snf_pkg::POINT_SEG : snf_pkg::BLANK_SEG);
            res.seg[3] = snf_pkg::seg_of(dig_u)
                       + ((point_reg == 2'd0) ? snf_pkg::POINT_SEG : snf_pkg::BLANK_SEG);
        end
    end

endmodule

@@ rtl/snf_merge.sv @@
// Merge stage: assembles the two lanes' segment bytes into one frame and
// streams it out one byte per transaction. Depends on snf_pkg.
module snf_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  snf_pkg::lane_res_t   lane_first,
    input  snf_pkg::lane_res_t   lane_second,
    input  logic [7:0]           ctrl_byte,
    output logic                 result_valid,
    input  logic                 result_ready,
    output snf_pkg::result_t     result
);

    logic       busy_reg;
    logic       busy_next;
    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic [4:0] last_pos_reg;
    logic [7:0] ctrl_reg;
    logic [7:0] data_reg [snf_pkg::FRAME_BYTES];

    logic at_last;
    logic take;
    logic frame_done;
    logic load;

    assign at_last    = (pos_reg == last_pos_reg);
    assign take       = busy_reg && result_ready;
    assign frame_done = take && at_last;
    assign src_ready  = !busy_reg || frame_done;
    assign load       = src_valid && src_ready;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = 5'd0;
        end
        else if (frame_done)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            pos_next = pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    // A large negative number cuts the frame short before that number.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= ctrl_byte;
            if (lane_first.stop)
                last_pos_reg <= snf_pkg::LAST_POS_NONE;
            else if (lane_second.stop)
                last_pos_reg <= snf_pkg::LAST_POS_ONE;
            else
                last_pos_reg <= snf_pkg::LAST_POS_BOTH;
            data_reg[0] <= snf_pkg::ADDR_BYTE;
            for (int j = 0; j < 4; j++)
            begin
                data_reg[1 + 2 * j]     <= lane_first.seg[j];
                data_reg[2 + 2 * j]     <= 8'h00;
                data_reg[9 + 2 * j]     <= lane_second.seg[j];
                data_reg[10 + 2 * j]    <= 8'h00;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < snf_pkg::FRAME_BYTES - 1; i++)
                data_reg[i] <= data_reg[i + 1];
            data_reg[snf_pkg::FRAME_BYTES - 1] <= 8'h00;
        end
    end

    assign result_valid    = busy_reg;
    assign result.out_byte = at_last ? ctrl_reg : data_reg[0];
    assign result.last     = at_last;

    always_comb
    begin
        priority if (pos_reg == 5'd0)
            result.byte_kind = snf_pkg::KIND_ADDR;
        else if (at_last)
            result.byte_kind = snf_pkg::KIND_CMD;
        else
            result.byte_kind = snf_pkg::KIND_DATA;
    end

endmodule

@@ rtl/seven_segment_number_formatter.sv @@
// Seven-segment number formatter: turns two fixed-point numbers plus brightness
// into one display frame of bytes. Depends on snf_pkg, snf_lane and snf_merge.
//
// Each accepted transaction carries two numbers, a brightness and an on/off flag,
// and produces one frame on the result channel: the address byte, a segment byte
// and a zero byte for each of the four digits of each number, and a closing
// control byte flagged by last. A frame is 18 bytes long, or 10 when the second
// number is negative with a magnitude of 2000 or more, or 2 when the first one
// is; magnitudes above 9999 show four dashes. The result channel moves one byte
// per cycle while result_ready is high, and that serialiser sets the sustained
// item rate. Two lanes, one per number, split the digits in parallel with
// reciprocal multipliers and hold the next item while the current frame streams
// out, so a new transaction is taken while a frame is still being sent and the
// next frame follows its predecessor without a gap. When the result side is idle,
// an accepted item is first registered in the lanes and then loaded into the merge
// stage, whose output is the frame's first byte. There are no configuration
// registers and nothing to initialise after reset.
module seven_segment_number_formatter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  snf_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output snf_pkg::result_t    result
);

    logic                stage_valid_reg;
    logic                stage_valid_next;
    logic [7:0]          ctrl_reg;
    logic [7:0]          ctrl_next;
    logic [2:0]          level;
    logic                accept;
    logic                merge_ready;
    snf_pkg::lane_res_t  lane_first;
    snf_pkg::lane_res_t  lane_second;

    // The lane stage is free when empty or when the merge stage takes its contents.
    assign item_ready = !stage_valid_reg || merge_ready;
    assign accept     = item_valid && item_ready;

    // Brightness is held to the range one to seven.
    always_comb
    begin
        priority if (item.bright_level > 8'd7)
            level = 3'd7;
        else if (item.bright_level == 8'd0)
            level = 3'd1;
        else
            level = item.bright_level[2:0];
        ctrl_next = snf_pkg::CTRL_BASE | {4'd0, item.display_on, level};
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (merge_ready)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ctrl_reg <= ctrl_next;
    end

    snf_lane u_lane_first
    (
        .clk   (clk),
        .load  (accept),
        .mag   (item.mag_first),
        .neg   (item.neg_first),
        .point (item.point_first),
        .res   (lane_first)
    );

    snf_lane u_lane_second
    (
        .clk   (clk),
        .load  (accept),
        .mag   (item.mag_second),
        .neg   (item.neg_second),
        .point (item.point_second),
        .res   (lane_second)
    );

    snf_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (stage_valid_reg),
        .src_ready    (merge_ready),
        .lane_first   (lane_first),
        .lane_second  (lane_second),
        .ctrl_byte    (ctrl_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
